>>> design/bhgc_pkg.sv
// ----------------------------------------------------------------------------
// bhgc_pkg
// Shared types, register indexes, reset values and the action decode for the
// button hold gesture classifier.
// ----------------------------------------------------------------------------
package bhgc_pkg;

   localparam int unsigned TickWidth = 16;

   typedef logic [TickWidth-1:0] tick_type;
   typedef logic [1:0]           stage_type;

   typedef enum logic [3:0] {
      ACT_NONE       = 4'd0,
      ACT_RESET      = 4'd1,
      ACT_STOP_INQ   = 4'd2,
      ACT_DISCONNECT = 4'd3,
      ACT_START_INQ  = 4'd4,
      ACT_FACTORY    = 4'd5,
      ACT_PWR_ON     = 4'd6,
      ACT_PWR_ON_RST = 4'd7,
      ACT_PWR_OFF    = 4'd8
   } action_type;

   typedef enum logic [2:0] {
      CSR_HOLD_FIRST  = 3'd0,
      CSR_HOLD_SECOND = 3'd1,
      CSR_HOLD_THIRD  = 3'd2,
      CSR_EXT_ADAPTER = 3'd3,
      CSR_INHIBIT     = 3'd4
   } csr_index_type;

   localparam tick_type HoldFirstReset  = 16'd100;
   localparam tick_type HoldSecondReset = 16'd300;
   localparam tick_type HoldThirdReset  = 16'd500;
   localparam logic     ExtAdapterReset = 1'b0;
   localparam tick_type InhibitReset    = 16'd200;

   localparam stage_type StageMax = 2'd3;

   typedef struct packed {
      tick_type hold_first;
      tick_type hold_second;
      tick_type hold_third;
      logic     ext_adapter;
      tick_type inhibit;
   } cfg_type;

   typedef struct packed {
      action_type action;
      logic       holding;
      stage_type  hold_stage;
   } result_type;

   // final stage runs 0..4 once the adapter bonus is added
   function automatic action_type pick_action(input logic       power_on,
                                              input logic       inquiry,
                                              input logic [2:0] final_stage);
      action_type act;
      if (power_on) begin
         case (final_stage)
            3'd0:    act = ACT_RESET;
            3'd1:    act = inquiry ? ACT_STOP_INQ : ACT_DISCONNECT;
            3'd2:    act = ACT_START_INQ;
            default: act = ACT_FACTORY;
         endcase
      end else begin
         act = (final_stage == 3'd0) ? ACT_PWR_ON : ACT_PWR_ON_RST;
      end
      return act;
   endfunction

endpackage

>>> design/bhgc_core.sv
// ----------------------------------------------------------------------------
// bhgc_core
// Press measurement, inhibit run and double press tracking. State advances
// by one tick per accepted transaction; the result of that tick is presented
// combinationally for the output register.
// ----------------------------------------------------------------------------
module bhgc_core (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 tick_en,
   input  logic                 button_pressed,
   input  logic                 power_sense,
   input  logic                 inquiry_active,
   input  bhgc_pkg::cfg_type    cfg,
   output bhgc_pkg::result_type result
);

   bhgc_pkg::tick_type  inhibit_left_ff, inhibit_left_in;
   logic                armed_ff, armed_in;
   logic                active_ff, active_in;
   bhgc_pkg::tick_type  ticks_ff, ticks_in;
   bhgc_pkg::stage_type stage_ff, stage_in;

   bhgc_pkg::action_type action;
   bhgc_pkg::tick_type   threshold;
   logic                 power_on;
   logic [2:0]           final_stage;

   assign power_on    = power_sense | cfg.ext_adapter;
   assign final_stage = {1'b0, stage_ff} + {2'b00, cfg.ext_adapter};

   always_comb begin
      case (stage_ff)
         2'd0:    threshold = cfg.hold_first;
         2'd1:    threshold = cfg.hold_second;
         default: threshold = cfg.hold_third;
      endcase
   end

   always_comb begin
      inhibit_left_in = inhibit_left_ff;
      armed_in        = armed_ff;
      active_in       = active_ff;
      ticks_in        = ticks_ff;
      stage_in        = stage_ff;
      action          = bhgc_pkg::ACT_NONE;

      if (inhibit_left_ff != '0) begin
         inhibit_left_in = inhibit_left_ff - 1'b1;
         if (armed_ff && power_on && button_pressed) begin
            action   = bhgc_pkg::ACT_PWR_OFF;
            armed_in = 1'b0;
         end
      end else begin
         armed_in = 1'b0;
         if (button_pressed) begin
            active_in = 1'b1;
            if (ticks_ff != '1) begin
               ticks_in = ticks_ff + 1'b1;
            end
            // compare uses the count after this tick
            if (stage_ff != bhgc_pkg::StageMax && ticks_in > threshold) begin
               stage_in = stage_ff + 1'b1;
            end
         end else if (active_ff) begin
            action          = bhgc_pkg::pick_action(power_on, inquiry_active, final_stage);
            armed_in        = power_on && (final_stage == 3'd0);
            active_in       = 1'b0;
            ticks_in        = '0;
            stage_in        = '0;
            inhibit_left_in = cfg.inhibit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         inhibit_left_ff <= '0;
         armed_ff        <= 1'b0;
         active_ff       <= 1'b0;
         ticks_ff        <= '0;
         stage_ff        <= '0;
      end else if (tick_en) begin
         inhibit_left_ff <= inhibit_left_in;
         armed_ff        <= armed_in;
         active_ff       <= active_in;
         ticks_ff        <= ticks_in;
         stage_ff        <= stage_in;
      end
   end

   assign result.action     = action;
   assign result.holding    = active_in;
   assign result.hold_stage = stage_in;

endmodule

>>> design/button_hold_gesture_classifier.sv
// ----------------------------------------------------------------------------
// button_hold_gesture_classifier
// Classifies button holds into actions, one tick transaction per 10 ms.
//
//   channel | direction | handshake          | payload
//   req     | in        | req_valid/req_stall| button, power sense, inquiry
//   rsp     | out       | rsp_valid/rsp_stall| action, holding, hold stage
//   csr     | in        | csr_write          | csr_index, csr_wdata
//
// One transaction per cycle; the result appears in the cycle after acceptance,
// from the output register. req_stall rises only while a result is held in
// the output register under rsp_stall. Synchronous reset clears the press
// state, the inhibit run and the output valid; registers load their defaults.
// ----------------------------------------------------------------------------
module button_hold_gesture_classifier (
   input  logic        clock,
   input  logic        reset,

   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_button_pressed,
   input  logic        req_power_sense,
   input  logic        req_inquiry_active,

   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [3:0]  rsp_action,
   output logic        rsp_holding,
   output logic [1:0]  rsp_hold_stage,

   input  logic        csr_write,
   input  logic [2:0]  csr_index,
   input  logic [15:0] csr_wdata
);

   bhgc_pkg::cfg_type    cfg_ff;
   bhgc_pkg::result_type result;
   bhgc_pkg::result_type rsp_ff;
   logic                 rsp_valid_ff;
   logic                 req_take;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.hold_first  <= bhgc_pkg::HoldFirstReset;
         cfg_ff.hold_second <= bhgc_pkg::HoldSecondReset;
         cfg_ff.hold_third  <= bhgc_pkg::HoldThirdReset;
         cfg_ff.ext_adapter <= bhgc_pkg::ExtAdapterReset;
         cfg_ff.inhibit     <= bhgc_pkg::InhibitReset;
      end else if (csr_write) begin
         unique case (bhgc_pkg::csr_index_type'(csr_index))
            bhgc_pkg::CSR_HOLD_FIRST:  cfg_ff.hold_first  <= csr_wdata;
            bhgc_pkg::CSR_HOLD_SECOND: cfg_ff.hold_second <= csr_wdata;
            bhgc_pkg::CSR_HOLD_THIRD:  cfg_ff.hold_third  <= csr_wdata;
            bhgc_pkg::CSR_EXT_ADAPTER: cfg_ff.ext_adapter <= csr_wdata[0];
            bhgc_pkg::CSR_INHIBIT:     cfg_ff.inhibit     <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign req_stall = rsp_valid_ff & rsp_stall;
   assign req_take  = req_valid & ~req_stall;

   bhgc_core u_core (
      .clock          (clock),
      .reset          (reset),
      .tick_en        (req_take),
      .button_pressed (req_button_pressed),
      .power_sense    (req_power_sense),
      .inquiry_active (req_inquiry_active),
      .cfg            (cfg_ff),
      .result         (result)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_take) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         rsp_ff <= result;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_action     = rsp_ff.action;
   assign rsp_holding    = rsp_ff.holding;
   assign rsp_hold_stage = rsp_ff.hold_stage;

endmodule

>>> design/bhgc_checker.sv
// ----------------------------------------------------------------------------
// bhgc_checker
// Port-level checks for the button hold gesture classifier.
// ----------------------------------------------------------------------------
module bhgc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [3:0]  rsp_action,
   input logic        rsp_holding,
   input logic [1:0]  rsp_hold_stage
);

   // a stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_action)
         && $stable(rsp_holding) && $stable(rsp_hold_stage))
      else $error("stalled result changed");

   // input only waits on a blocked output register
   a_no_idle_stall: assert property (@(posedge clock) disable iff (reset)
      !(rsp_valid && rsp_stall) |-> !req_stall)
      else $error("input stalled without backpressure");

   // every accepted tick yields a result next cycle
   a_result_follows: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted tick produced no result");

   a_stage_idle: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_holding |-> rsp_hold_stage == 2'd0)
      else $error("hold stage nonzero outside a press");

   // actions only come on release or in the inhibit run
   a_action_released: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_action != bhgc_pkg::ACT_NONE |-> !rsp_holding)
      else $error("action reported while holding");

endmodule

bind button_hold_gesture_classifier bhgc_checker u_bhgc_checker (.*);
